FILE: rtl/apq_pkg.sv
package apq_pkg;

  localparam int unsigned PIXEL_CAPACITY = 4096;
  localparam int unsigned PALETTE_DEPTH  = 256;
  localparam int unsigned REPLACE_WINDOW = 16;

  localparam int unsigned PIX_AW = $clog2(PIXEL_CAPACITY);
  localparam int unsigned PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(PIXEL_CAPACITY + 1);
  localparam int unsigned SCAN_W = PAL_AW + 1;
  // max L1 distance is 3 * 255 = 765
  localparam int unsigned DIST_W = 10;

  localparam logic [15:0] MATCH_MASK = 16'hf7de;

  localparam logic RK_WORD  = 1'b0;
  localparam logic RK_INDEX = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_QUANT   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  palette_slot;
    logic [11:0] pixel_address;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] palette_color;
    logic [7:0]  color_index;
  } out_t;

  // 3-3-2 derived start palette
  function automatic logic [15:0] pal_init(input logic [7:0] idx);
    return {idx[7:5], 2'b00, idx[4:2], 3'b000, idx[1:0], 3'b000};
  endfunction

endpackage

FILE: rtl/adaptive_palette_quantizer_unit.sv
// Adaptive palette quantizer.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one word per op:
//   load pixel (RGB888 -> RGB565, stored and used to adapt the palette),
//   read palette word, quantize stored pixel, restart image.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns one word
//   for read and quantize ops, none for load and restart.
// Op sequence, set by the single palette RAM read port feeding one compare unit
//   (one palette entry per cycle):
//   read palette word: palette RAM read, result register, output register.
//   load: accept and pixel write, scan of up to 256 entries, then S_WRA and
//     S_WRB writes (only S_WRB on a miss, none on a hit at entry 0).
//   quantize: pixel RAM read, scan (stops at an exact match), output register.
//   restart: done in the idle state.
// in_stall_o is high while an op is in progress. A finished result waits in
//   its slot while the output register is full and stalled.
// Reset: loaded count goes to 0 and every palette entry reads its 3-3-2
//   start value (per-entry valid bits). Pixel contents are not cleared.
module adaptive_palette_quantizer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  apq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output apq_pkg::out_t out_data_o
);
  import apq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PAL  = 7'b0000010,
    S_PIX  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_WRA  = 7'b0010000,
    S_WRB  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [15:0]              color_q, color_d;
  logic                     quant_q, quant_d;
  logic [SCAN_W-1:0]        scan_q, scan_d;
  logic                     dvld_q, dvld_d;
  logic [PAL_AW-1:0]        pidx_q;
  logic                     pv_q;
  logic [PALETTE_DEPTH-1:0] valid_q, valid_d;
  logic [15:0]              prev_q, prev_d;
  logic [DIST_W-1:0]        best_q, best_d;
  logic [PAL_AW-1:0]        bidx_q, bidx_d;
  logic [PAL_AW-1:0]        hit_q, hit_d;
  logic [PAL_AW-1:0]        wr_addr_q, wr_addr_d;
  out_t                     res_q, res_d;
  out_t                     out_q;
  logic                     out_vld_q;

  // RAM ports
  logic              pal_re, pal_we;
  logic [PAL_AW-1:0] pal_raddr, pal_waddr;
  logic [15:0]       pal_wdata, pal_rdata;
  logic              pix_re, pix_we;
  logic [PIX_AW-1:0] pix_raddr, pix_waddr;
  logic [15:0]       pix_wdata, pix_rdata;

  logic [15:0]       entry;
  logic              match;
  logic              last;
  logic              closer;
  logic              out_free;
  logic [DIST_W-1:0] pal_dist;
  logic [PAL_AW-1:0] miss_slot;

  apq_ram #(.Width(16), .Depth(PALETTE_DEPTH)) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(pal_waddr),
    .wdata_i(pal_wdata),
    .re_i   (pal_re),
    .raddr_i(pal_raddr),
    .rdata_o(pal_rdata)
  );

  apq_ram #(.Width(16), .Depth(PIXEL_CAPACITY)) u_pix_ram (
    .clk_i  (clk_i),
    .we_i   (pix_we),
    .waddr_i(pix_waddr),
    .wdata_i(pix_wdata),
    .re_i   (pix_re),
    .raddr_i(pix_raddr),
    .rdata_o(pix_rdata)
  );

  // single distance unit (quantize scans), one palette entry per cycle
  apq_dist u_dist (
    .target_i(color_q),
    .entry_i (entry),
    .dist_o  (pal_dist)
  );

  // entry never written since reset/restart reads its start value
  assign entry     = pv_q ? pal_rdata : pal_init(pidx_q);
  assign match     = (entry & MATCH_MASK) == (color_q & MATCH_MASK);
  assign last      = pidx_q == PAL_AW'(PALETTE_DEPTH - 1);
  assign closer    = pal_dist < best_q;
  assign miss_slot = PAL_AW'(PALETTE_DEPTH - 1)
                   - PAL_AW'((cnt_q % REPLACE_WINDOW) % PALETTE_DEPTH);
  assign out_free  = !out_vld_q || !out_stall_i;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    color_d   = color_q;
    quant_d   = quant_q;
    scan_d    = scan_q;
    dvld_d    = 1'b0;
    valid_d   = valid_q;
    prev_d    = prev_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    hit_d     = hit_q;
    wr_addr_d = wr_addr_q;
    res_d     = res_q;

    pal_re    = 1'b0;
    pal_raddr = '0;
    pal_we    = 1'b0;
    pal_waddr = '0;
    pal_wdata = color_q;
    pix_re    = 1'b0;
    pix_raddr = in_data_i.pixel_address[PIX_AW-1:0];
    pix_we    = 1'b0;
    pix_waddr = cnt_q[PIX_AW-1:0];
    pix_wdata = {in_data_i.red[7:3], in_data_i.green[7:2], in_data_i.blue[7:3]};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.op)
            OP_LOAD: begin
              // full store: word dropped
              if (cnt_q < CNT_W'(PIXEL_CAPACITY)) begin
                pix_we  = 1'b1;
                color_d = pix_wdata;
                quant_d = 1'b0;
                scan_d  = '0;
                state_d = S_SCAN;
              end
            end
            OP_READ: begin
              pal_re    = 1'b1;
              pal_raddr = in_data_i.palette_slot[PAL_AW-1:0];
              state_d   = S_PAL;
            end
            OP_QUANT: begin
              pix_re  = 1'b1;
              quant_d = 1'b1;
              state_d = S_PIX;
            end
            OP_RESTART: begin
              cnt_d   = '0;
              valid_d = '0;
            end
          endcase
        end
      end

      S_PAL: begin
        res_d.result_kind   = RK_WORD;
        res_d.palette_color = entry;
        res_d.color_index   = '0;
        state_d             = S_OUT;
      end

      S_PIX: begin
        color_d = pix_rdata;
        scan_d  = '0;
        best_d  = '1;
        bidx_d  = '0;
        state_d = S_SCAN;
      end

      S_SCAN: begin
        // read side: issue next address
        if (scan_q < SCAN_W'(PALETTE_DEPTH)) begin
          pal_re    = 1'b1;
          pal_raddr = scan_q[PAL_AW-1:0];
          scan_d    = scan_q + SCAN_W'(1);
          dvld_d    = 1'b1;
        end
        // compare side: entry returned by last cycle's read
        if (dvld_q) begin
          if (quant_q) begin
            if (pal_dist == '0) begin
              res_d.result_kind   = RK_INDEX;
              res_d.palette_color = '0;
              res_d.color_index   = pidx_q;
              state_d             = S_OUT;
            end else begin
              if (closer) begin
                best_d = pal_dist;
                bidx_d = pidx_q;
              end
              if (last) begin
                res_d.result_kind   = RK_INDEX;
                res_d.palette_color = '0;
                res_d.color_index   = closer ? pidx_q : bidx_q;
                state_d             = S_OUT;
              end
            end
          end else begin
            if (match) begin
              if (pidx_q == '0) begin
                cnt_d   = cnt_q + CNT_W'(1);
                state_d = S_IDLE;
              end else begin
                // swap toward the front: entry j <- old j-1, j-1 <- color
                hit_d     = pidx_q;
                wr_addr_d = pidx_q - PAL_AW'(1);
                state_d   = S_WRA;
              end
            end else begin
              // keep the last non-matching entry for the swap
              prev_d = entry;
              if (last) begin
                wr_addr_d = miss_slot;
                state_d   = S_WRB;
              end
            end
          end
        end
      end

      S_WRA: begin
        pal_we         = 1'b1;
        pal_waddr      = hit_q;
        pal_wdata      = prev_q;
        valid_d[hit_q] = 1'b1;
        state_d        = S_WRB;
      end

      S_WRB: begin
        pal_we             = 1'b1;
        pal_waddr          = wr_addr_q;
        pal_wdata          = color_q;
        valid_d[wr_addr_q] = 1'b1;
        cnt_d              = cnt_q + CNT_W'(1);
        state_d            = S_IDLE;
      end

      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      dvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      dvld_q  <= dvld_d;
      if (state_q == S_OUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    color_q   <= color_d;
    quant_q   <= quant_d;
    scan_q    <= scan_d;
    prev_q    <= prev_d;
    best_q    <= best_d;
    bidx_q    <= bidx_d;
    hit_q     <= hit_d;
    wr_addr_q <= wr_addr_d;
    res_q     <= res_d;
    // valid bit and index travel with the registered RAM read
    if (pal_re) begin
      pv_q   <= valid_q[pal_raddr];
      pidx_q <= pal_raddr;
    end
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
  end

endmodule

FILE: rtl/apq_ram.sv
module apq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/apq_dist.sv
module apq_dist (
  input  logic [15:0]                target_i,
  input  logic [15:0]                entry_i,
  output logic [apq_pkg::DIST_W-1:0] dist_o
);
  import apq_pkg::*;

  function automatic logic [7:0] exp5(input logic [4:0] v);
    return (v == 5'd31) ? 8'd255 : {v, 3'b000};
  endfunction

  function automatic logic [7:0] exp6(input logic [5:0] v);
    return (v == 6'd63) ? 8'd255 : {v, 2'b00};
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [7:0] dr, dg, db;

  assign dr = absdiff(exp5(target_i[15:11]), exp5(entry_i[15:11]));
  assign dg = absdiff(exp6(target_i[10:5]),  exp6(entry_i[10:5]));
  assign db = absdiff(exp5(target_i[4:0]),   exp5(entry_i[4:0]));

  assign dist_o = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);

endmodule
